// File: src/prcf_pkg.sv
// Package with the shared types and constants of the pixel color range filter.
`default_nettype none
package prcf_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned THR_W    = 13;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned NUM_W    = 42;
  localparam int unsigned DEN_W    = 18;
  localparam int unsigned TSQ_W    = 27;
  localparam int unsigned PROD_W   = 45;
  localparam int unsigned FRAC_BITS = 12;

  // Three times 255 squared, the full scale of the squared distance.
  localparam logic [DEN_W-1:0] FULL_SQ_SUM = 18'd195075;
  localparam logic [DEN_W-1:0] CHAN_MAX    = 18'd255;

  localparam logic [MODE_W-1:0] MODE_DIST  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HUE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SAT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VALUE = 3'd4;

  localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_HIGH = 3'd2;
  localparam logic [IDX_W-1:0] REG_BG   = 3'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  low;
    logic [THR_W-1:0]  high;
    logic [RGB_W-1:0]  bg;
  } cfg_t;

  // Word handed from the preparation stages to the compare stages.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [TSQ_W-1:0] tlo;
    logic [TSQ_W-1:0] thi;
    logic             kill;
    logic             wrap;
  } mid_t;

endpackage
`default_nettype wire

// File: src/prcf_if.sv
// Stream and configuration interfaces of the pixel color range filter.
`default_nettype none
interface prcf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface prcf_bit_if;
  logic valid;
  logic ready;
  logic pixel_on;
  modport source (output valid, output pixel_on, input ready);
  modport sink   (input valid, input pixel_on, output ready);
endinterface

interface prcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/prcf_cfg.sv
// Configuration register file of the pixel color range filter.
`default_nettype none
module prcf_cfg (
  input  wire logic    clk,
  input  wire logic    rst_n,
  prcf_cfg_if.sink     cfg,
  output prcf_pkg::cfg_t cfg_q
);
  import prcf_pkg::*;

  cfg_t cfg_r;

  assign cfg.ready = 1'b1;
  assign cfg_q     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_DIST;
      cfg_r.low  <= '0;
      cfg_r.high <= 13'd4096;
      cfg_r.bg   <= 24'hFFFFFF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODE: cfg_r.mode <= cfg.data[MODE_W-1:0];
        REG_LOW:  cfg_r.low  <= cfg.data[THR_W-1:0];
        REG_HIGH: cfg_r.high <= cfg.data[THR_W-1:0];
        REG_BG:   cfg_r.bg   <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/prcf_prep.sv
// Preparation stages: color extremes, squares, hue sector and threshold terms.
`default_nettype none
module prcf_prep (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire prcf_pkg::cfg_t cfg_q,
  prcf_pix_if.sink            pix,
  output logic                mid_valid,
  input  wire logic           mid_ready,
  output prcf_pkg::mid_t      mid
);
  import prcf_pkg::*;

  logic v1_r, v2_r, en1, en2;
  logic [CHAN_W-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  logic [CHAN_W-1:0] mx1_nxt, mn1_nxt;
  logic signed [CHAN_W:0] dr1_r, dg1_r, db1_r;
  logic bgm1_r;
  mid_t mid_r, mid_nxt;

  assign en2       = !v2_r || mid_ready;
  assign en1       = !v1_r || en2;
  assign pix.ready = en1;
  assign mid_valid = v2_r;
  assign mid       = mid_r;

  always_comb begin
    mx1_nxt = pix.red;
    mn1_nxt = pix.red;
    if (pix.green > mx1_nxt) mx1_nxt = pix.green;
    if (pix.blue  > mx1_nxt) mx1_nxt = pix.blue;
    if (pix.green < mn1_nxt) mn1_nxt = pix.green;
    if (pix.blue  < mn1_nxt) mn1_nxt = pix.blue;
  end

  // Stage two: squared sums, hue sector numerator and the threshold terms.
  logic [CHAN_W-1:0]   delta;
  logic [DEN_W-1:0]    dsq;
  logic signed [11:0]  hn;
  logic                sq_mode;
  logic [THR_W:0]      hi1;

  always_comb begin
    delta = mx1_r - mn1_r;
    sq_mode = (cfg_q.mode == MODE_DIST) || (cfg_q.mode == MODE_INT);
    if (cfg_q.mode == MODE_DIST)
      dsq = DEN_W'(dr1_r * dr1_r) + DEN_W'(dg1_r * dg1_r) + DEN_W'(db1_r * db1_r);
    else
      dsq = DEN_W'(r1_r * r1_r) + DEN_W'(g1_r * g1_r) + DEN_W'(b1_r * b1_r);
    if (r1_r == mx1_r) begin
      hn = $signed({4'd0, g1_r}) - $signed({4'd0, b1_r});
      if (hn < 0) hn = hn + $signed(12'(6 * delta));
    end else if (g1_r == mx1_r) begin
      hn = $signed(12'(2 * delta)) + $signed({4'd0, b1_r}) - $signed({4'd0, r1_r});
    end else begin
      hn = $signed(12'(4 * delta)) + $signed({4'd0, r1_r}) - $signed({4'd0, g1_r});
    end
    hi1 = {1'b0, cfg_q.high} + 14'd1;
    mid_nxt.kill = bgm1_r;
    mid_nxt.wrap = cfg_q.low > cfg_q.high;
    if (sq_mode) begin
      mid_nxt.tlo = TSQ_W'(cfg_q.low * cfg_q.low);
      mid_nxt.thi = TSQ_W'(hi1 * hi1);
    end else begin
      mid_nxt.tlo = TSQ_W'(cfg_q.low);
      mid_nxt.thi = TSQ_W'(hi1);
    end
    unique case (cfg_q.mode)
      MODE_DIST, MODE_INT: begin
        mid_nxt.num = NUM_W'(dsq) << 24;
        mid_nxt.den = FULL_SQ_SUM;
      end
      MODE_HUE: begin
        mid_nxt.num = NUM_W'(hn[10:0]) << FRAC_BITS;
        mid_nxt.den = DEN_W'(6 * delta);
        if (delta == '0) mid_nxt.kill = 1'b1;
      end
      MODE_SAT: begin
        mid_nxt.num = NUM_W'(delta) << FRAC_BITS;
        mid_nxt.den = (mx1_r == '0) ? DEN_W'(1) : DEN_W'(mx1_r);
      end
      MODE_VALUE: begin
        mid_nxt.num = NUM_W'(mx1_r) << FRAC_BITS;
        mid_nxt.den = CHAN_MAX;
      end
      default: begin
        mid_nxt.num  = '0;
        mid_nxt.den  = DEN_W'(1);
        mid_nxt.kill = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= pix.valid;
      if (en2) v2_r <= v1_r;
    end
    if (en1) begin
      r1_r   <= pix.red;
      g1_r   <= pix.green;
      b1_r   <= pix.blue;
      mx1_r  <= mx1_nxt;
      mn1_r  <= mn1_nxt;
      dr1_r  <= $signed({1'b0, pix.red})   - $signed({1'b0, cfg_q.bg[23:16]});
      dg1_r  <= $signed({1'b0, pix.green}) - $signed({1'b0, cfg_q.bg[15:8]});
      db1_r  <= $signed({1'b0, pix.blue})  - $signed({1'b0, cfg_q.bg[7:0]});
      bgm1_r <= {pix.red, pix.green, pix.blue} == cfg_q.bg;
    end
    if (en2) mid_r <= mid_nxt;
  end
endmodule
`default_nettype wire

// File: src/prcf_cmp.sv
// Compare stages: scaled threshold products and the final range decision.
`default_nettype none
module prcf_cmp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           mid_valid,
  output logic                mid_ready,
  input  wire prcf_pkg::mid_t mid,
  prcf_bit_if.source          res
);
  import prcf_pkg::*;

  logic v3_r, v4_r, en3, en4;
  logic [NUM_W-1:0]  num3_r;
  logic [PROD_W-1:0] plo3_r, phi3_r;
  logic kill3_r, wrap3_r, on4_r, on_nxt, ge, lt;

  assign en4       = !v4_r || res.ready;
  assign en3       = !v3_r || en4;
  assign mid_ready = en3;
  assign res.valid = v4_r;
  assign res.pixel_on = on4_r;

  always_comb begin
    ge = PROD_W'(num3_r) >= plo3_r;
    lt = PROD_W'(num3_r) <  phi3_r;
    if (kill3_r)      on_nxt = 1'b0;
    else if (wrap3_r) on_nxt = ge || lt;
    else              on_nxt = ge && lt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= mid_valid;
      if (en4) v4_r <= v3_r;
    end
    if (en3) begin
      num3_r  <= mid.num;
      plo3_r  <= PROD_W'(mid.tlo * mid.den);
      phi3_r  <= PROD_W'(mid.thi * mid.den);
      kill3_r <= mid.kill;
      wrap3_r <= mid.wrap;
    end
    if (en4) on4_r <= on_nxt;
  end
endmodule
`default_nettype wire

// File: src/pixel_color_range_filter.sv
// Pipeline: four stage registers lie between an accepted pixel word and its result word.
// Throughput: one pixel per clock while the output is ready; each stage register
// advances when the next one can take its word, so a bubble is filled while the output waits.
// Reset (rst_n, synchronous, low): all stage valid bits clear, mode becomes
// distance, thresholds 0 and 4096, background white.
`default_nettype none
module pixel_color_range_filter (
  input  wire logic   clk,
  input  wire logic   rst_n,
  prcf_pix_if.sink    in_ch,
  prcf_bit_if.source  out_ch,
  prcf_cfg_if.sink    cfg_ch
);
  import prcf_pkg::*;

  // The measure is never formed as a quotient or root. Each mode gives a
  // numerator and a denominator, and the thresholds are scaled by the
  // denominator instead; in the root modes the thresholds are squared first,
  // since the root reaches a bound exactly when its argument reaches the
  // square of that bound.
  cfg_t cfg_q;
  mid_t mid;
  logic mid_valid, mid_ready;

  prcf_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_q (cfg_q)
  );

  // Stages one and two: extremes and differences, then squares and terms.
  prcf_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_q     (cfg_q),
    .pix       (in_ch),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // Stages three and four: threshold products, then the range decision.
  prcf_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .res       (out_ch)
  );
endmodule
`default_nettype wire

// File: dv/tb_pixel_color_range_filter.sv
// Self-checking testbench for the pixel color range filter with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_pixel_color_range_filter;
  import prcf_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk;
  logic rst_n;

  prcf_pix_if pix ();
  prcf_bit_if res ();
  prcf_cfg_if cfg ();

  pixel_color_range_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix.sink),
    .out_ch (res.source),
    .cfg_ch (cfg.sink)
  );

  // The clock has a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // This is the testbench's own copy of the configuration registers.
  // It is updated when a configuration word is accepted.
  logic [2:0]  cur_mode;
  logic [12:0] cur_low;
  logic [12:0] cur_high;
  logic [23:0] cur_bg;

  // These are the pixels still waiting to be offered, and the bits
  // that the block is expected to return, oldest first.
  pixel_t pending_pixels[$];
  bit     expected_bits[$];

  // These settings control idling. The percentages give how often
  // each side idles. The receiver also has a long hold-off that
  // counts down in cycles.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          hold_off_cycles;
  bit          hold_off_req;

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned pixels_sent;
  longint      cycle_count;

  // This is set at the rising edge at which the block takes the offered pixel.
  bit          in_taken;

  // This is the integer square root of v. It returns floor(sqrt(v)).
  function automatic int unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return int'(root);
  endfunction

  // This maps a sum of squares onto the Q1.12 scale, where the largest
  // possible sum (three times 255 squared) gives 4096.
  function automatic int unsigned scaled_norm(longint unsigned sq);
    return floor_sqrt((sq << 24) / 195075);
  endfunction

  // This predicts the on/off bit for one pixel under the current settings.
  function automatic bit predict_pixel_on(pixel_t p);
    int r, g, b, mx, mn, delta, n, dr, dg, db;
    int unsigned s;
    bit has_measure;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    has_measure = 1'b1;
    s = 0;
    if (p == pixel_t'(cur_bg)) return 1'b0;
    case (cur_mode)
      MODE_DIST: begin
        dr = r - int'(cur_bg[23:16]);
        dg = g - int'(cur_bg[15:8]);
        db = b - int'(cur_bg[7:0]);
        s  = scaled_norm(longint'(dr*dr + dg*dg + db*db));
      end
      MODE_HUE: begin
        // An achromatic pixel has no hue, so it is always off.
        if (delta == 0) begin
          has_measure = 1'b0;
        end else begin
          if (r == mx) begin
            n = g - b;
            if (n < 0) n += 6 * delta;
          end else if (g == mx) begin
            n = 2 * delta + b - r;
          end else begin
            n = 4 * delta + r - g;
          end
          s = (4096 * n) / (6 * delta);
        end
      end
      MODE_INT:   s = scaled_norm(longint'(r*r + g*g + b*b));
      MODE_SAT:   s = (mx == 0) ? 0 : (4096 * delta) / mx;
      MODE_VALUE: s = (4096 * mx) / 255;
      // An undefined mode has no measure.
      default:    has_measure = 1'b0;
    endcase
    if (!has_measure) return 1'b0;
    // When low is above high, the accepted band wraps around.
    if (cur_low <= cur_high) return (cur_low <= s) && (s <= cur_high);
    return (s <= cur_high) || (cur_low <= s);
  endfunction

  // The input handshake is sampled on the rising edge, where the word
  // is actually taken.
  always @(posedge clk) begin
    in_taken = rst_n && pix.valid && pix.ready;
  end

  // The driver changes inputs on the falling edge. It first retires the
  // word taken at the last rising edge, then keeps a word that is still
  // waiting on the lines unchanged, or else decides what to offer next.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        expected_bits.push_back(predict_pixel_on(pending_pixels.pop_front()));
        pixels_sent++;
      end
      if (!pix.valid || in_taken) begin
        if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          pix.valid <= 1'b1;
          pix.red   <= pending_pixels[0].red;
          pix.green <= pending_pixels[0].green;
          pix.blue  <= pending_pixels[0].blue;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // The receiver drives ready on the falling edge and counts its own
  // long hold-off in cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_req) begin
        hold_off_cycles = 300;
        hold_off_req    = 1'b0;
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // The monitor samples outputs on the rising edge and checks each
  // result word against the oldest expected bit.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && res.valid && res.ready) begin
      results_seen++;
      if (expected_bits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: pixel_on=%0b", res.pixel_on);
      end else if (res.pixel_on !== expected_bits[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected pixel_on=%0b, got %0b",
                   results_seen, expected_bits[0], res.pixel_on);
        void'(expected_bits.pop_front());
      end else begin
        void'(expected_bits.pop_front());
      end
    end
    // If the run goes past this limit, it has hung.
    if (cycle_count > 400000) begin
      $display("timeout with %0d results outstanding", expected_bits.size());
      $display("pixel_color_range_filter: mismatch");
      $finish;
    end
  end

  // This writes one configuration register at the falling edge and waits
  // for it to be accepted. It is used only while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_MODE: cur_mode = value[2:0];
      REG_LOW:  cur_low  = value[12:0];
      REG_HIGH: cur_high = value[12:0];
      REG_BG:   cur_bg   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_config(logic [2:0] mode, logic [12:0] low, logic [12:0] high,
                            logic [23:0] bg);
    write_reg(REG_MODE, {21'd0, mode});
    write_reg(REG_LOW,  {11'd0, low});
    write_reg(REG_HIGH, {11'd0, high});
    write_reg(REG_BG,   bg);
  endtask

  // This waits until every queued pixel has been sent and every result
  // has arrived. It then lets the pipeline settle before returning.
  task automatic drain();
    while (pending_pixels.size() != 0 || pix.valid || expected_bits.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    case ($urandom_range(4, 0))
      0: p = pixel_t'({$urandom_range(1, 0) ? 8'hFF : 8'h00,
                       $urandom_range(1, 0) ? 8'hFF : 8'h00,
                       $urandom_range(1, 0) ? 8'hFF : 8'h00});
      // This case makes a grey pixel, which has no hue.
      1: begin
        p.red   = 8'($urandom_range(255, 0));
        p.green = p.red;
        p.blue  = p.red;
      end
      2: p = pixel_t'(cur_bg ^ (24'd1 << $urandom_range(23, 0)));
      3: p = pixel_t'(cur_bg);
      default: p = pixel_t'(24'($urandom));
    endcase
    return p;
  endfunction

  // This picks a random threshold: 0, 4096, the largest 13-bit value, or a value up to 4096.
  function automatic logic [12:0] random_threshold();
    case ($urandom_range(5, 0))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'h1FFF;
      default: return 13'($urandom_range(4096, 0));
    endcase
  endfunction

  initial begin
    pixel_t p;
    int phase;
    clk = 1'b0;
    rst_n = 1'b0;
    pix.valid = 1'b0;
    pix.red = 8'd0;
    pix.green = 8'd0;
    pix.blue = 8'd0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    send_idle_pct = 21;
    recv_idle_pct = 69;
    hold_off_cycles = 0;
    hold_off_req = 1'b0;
    mismatches = 0;
    results_seen = 0;
    pixels_sent = 0;
    cycle_count = 0;
    cur_mode = MODE_DIST;
    cur_low = 13'd0;
    cur_high = 13'd4096;
    cur_bg = 24'hFFFFFF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The directed part starts with the reset settings. It covers extreme
    // pixels, the background match and a pixel one bit away from it.
    pending_pixels = '{24'h000000, 24'hFFFFFF, 24'hFFFFFE, 24'hFF0000, 24'h00FF00,
                       24'h0000FF, 24'h808080};
    drain();
    // In hue mode, the sectors are checked, including a grey pixel and
    // red as the maximum with blue above green.
    set_config(MODE_HUE, 13'd0, 13'd4096, 24'h123456);
    pending_pixels = '{24'hFF0000, 24'hFF00FF, 24'h00FF80, 24'h4000FF, 24'h777777,
                       24'h123456};
    drain();
    // In the saturation and value modes, a wrapped band and thresholds
    // above 4096 are covered. Black is included here.
    set_config(MODE_SAT, 13'd3000, 13'd100, 24'h000001);
    pending_pixels = '{24'h000000, 24'hFF8000, 24'h7F7F7F};
    drain();
    set_config(MODE_VALUE, 13'h1FFF, 13'h1FFF, 24'hFFFFFF);
    pending_pixels = '{24'hFFFFFF, 24'hFF0000, 24'h010101};
    drain();
    // Mode 5 is undefined, so every pixel is off. A write to an index
    // beyond the register list must be ignored.
    set_config(3'd5, 13'd0, 13'd4096, 24'h000000);
    write_reg(3'd6, 24'hABCDEF);
    pending_pixels = '{24'h102030, 24'hFFFFFF};
    drain();
    set_config(MODE_INT, 13'd2048, 13'd4096, 24'h000000);
    pending_pixels = '{24'hFFFFFF, 24'h000001, 24'h808080};
    drain();

    // The random part runs in three idling regimes. Each regime has
    // several configuration phases.
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 21;
      end
      if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(3'($urandom_range(7, 0)), random_threshold(), random_threshold(),
                 24'($urandom));
      // In one phase, the receiver stalls for a long stretch while
      // pixels keep arriving.
      if (phase == 9) hold_off_req = 1'b1;
      repeat (108) begin
        p = random_pixel();
        pending_pixels.push_back(p);
      end
      // The sender pauses here, at each phase end, until all results are in.
      drain();
    end

    $display("covered %0d pixels and %0d results over 12 random settings plus directed cases",
             pixels_sent, results_seen);
    if (mismatches == 0) begin
      $display("pixel_color_range_filter: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("pixel_color_range_filter: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
src/prcf_pkg.sv
src/prcf_if.sv
src/prcf_cfg.sv
src/prcf_prep.sv
src/prcf_cmp.sv
src/pixel_color_range_filter.sv
dv/tb_pixel_color_range_filter.sv
